// ----- rtl/pscr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package pscr_pkg;

	// Screen modes as reported on the result channel.
	typedef enum logic [1:0] {
		MODE_ACTIVE  = 2'd0,
		MODE_ALERT   = 2'd1,
		MODE_SUMMARY = 2'd2,
		MODE_SLEEP   = 2'd3
	} mode_t;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SIT_THRESHOLD = 3'd0,
		CFG_RESET_DELAY   = 3'd1,
		CFG_SUMMARY_DELAY = 3'd2,
		CFG_SLEEP_DELAY   = 3'd3,
		CFG_ALERT_DISMISS = 3'd4
	} cfg_idx_t;

	localparam int TIME_W = 32;
	localparam int SEC_W  = 23;

	// Register values after reset, in milliseconds.
	localparam logic [TIME_W-1:0] SIT_THRESHOLD_RST = 32'd1800000;
	localparam logic [TIME_W-1:0] RESET_DELAY_RST   = 32'd10000;
	localparam logic [TIME_W-1:0] SUMMARY_DELAY_RST = 32'd30000;
	localparam logic [TIME_W-1:0] SLEEP_DELAY_RST   = 32'd300000;
	localparam logic [TIME_W-1:0] ALERT_DISMISS_RST = 32'd60000;

	// Milliseconds to seconds: x / 1000 == (x * ceil(2^38 / 1000)) >> 38 for 32-bit x.
	localparam int MS_PER_SEC = 1000;
	localparam int DIV_SHIFT  = 38;
	localparam int MAGIC_W    = 29;
	localparam logic [MAGIC_W-1:0] DIV_MAGIC = 29'd274877907;

	// Thresholds held by the configuration block.
	typedef struct packed {
		logic [TIME_W-1:0] sit_threshold_ms;
		logic [TIME_W-1:0] reset_delay_ms;
		logic [TIME_W-1:0] summary_delay_ms;
		logic [TIME_W-1:0] sleep_delay_ms;
		logic [TIME_W-1:0] alert_dismiss_ms;
	} cfg_t;

	// Outcome of one tick before conversion to seconds.
	typedef struct packed {
		mode_t             mode;
		logic              changed;
		logic [TIME_W-1:0] countdown_ms;
		logic [TIME_W-1:0] sit_accum_ms;
	} step_t;

endpackage

`default_nettype wire

// ----- rtl/pscr_cfg.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pscr_cfg (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire  [pscr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire  [pscr_pkg::TIME_W-1:0]      cfg_data,
	output pscr_pkg::cfg_t                   cfg
);

	pscr_pkg::cfg_t cfg_q;

	// The register file takes a beat in every cycle.
	assign cfg_ready = 1'b1;
	assign cfg      = cfg_q;

	// Register writes; indexes past the last register are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sit_threshold_ms <= pscr_pkg::SIT_THRESHOLD_RST;
			cfg_q.reset_delay_ms   <= pscr_pkg::RESET_DELAY_RST;
			cfg_q.summary_delay_ms <= pscr_pkg::SUMMARY_DELAY_RST;
			cfg_q.sleep_delay_ms   <= pscr_pkg::SLEEP_DELAY_RST;
			cfg_q.alert_dismiss_ms <= pscr_pkg::ALERT_DISMISS_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				pscr_pkg::CFG_SIT_THRESHOLD: cfg_q.sit_threshold_ms <= cfg_data;
				pscr_pkg::CFG_RESET_DELAY:   cfg_q.reset_delay_ms   <= cfg_data;
				pscr_pkg::CFG_SUMMARY_DELAY: cfg_q.summary_delay_ms <= cfg_data;
				pscr_pkg::CFG_SLEEP_DELAY:   cfg_q.sleep_delay_ms   <= cfg_data;
				pscr_pkg::CFG_ALERT_DISMISS: cfg_q.alert_dismiss_ms <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- rtl/pscr_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pscr_core (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          step_en,
	input  wire                          present,
	input  wire  [pscr_pkg::TIME_W-1:0]  now,
	input  wire  pscr_pkg::cfg_t         cfg,
	output pscr_pkg::step_t              step
);

	localparam int W = pscr_pkg::TIME_W;

	pscr_pkg::mode_t mode_q;
	logic [W-1:0]    accum_q;
	logic            was_present_q;
	logic [W-1:0]    last_present_q;
	logic            absent_q;
	logic [W-1:0]    absent_start_q;
	logic [W-1:0]    alert_start_q;

	pscr_pkg::mode_t mode_d;
	logic [W-1:0]    accum_d;
	logic            was_present_d;
	logic [W-1:0]    last_present_d;
	logic            absent_d;
	logic [W-1:0]    absent_start_d;
	logic [W-1:0]    alert_start_d;

	logic [W:0]      accum_sum;
	logic [W-1:0]    accum_upd;
	logic [W-1:0]    absent_ms;
	logic            clear_cd;

	// Presence tracking: sitting time grows between consecutive present ticks.
	always_comb begin
		accum_sum      = {1'b0, accum_q} + {1'b0, now - last_present_q};
		accum_upd      = accum_q;
		was_present_d  = was_present_q;
		last_present_d = last_present_q;
		absent_d       = absent_q;
		absent_start_d = absent_start_q;
		if (present) begin
			if (was_present_q) begin
				accum_upd = accum_sum[W] ? {W{1'b1}} : accum_sum[W-1:0];
			end
			last_present_d = now;
			was_present_d  = 1'b1;
			absent_d       = 1'b0;
		end else begin
			was_present_d = 1'b0;
			if (!absent_q) begin
				absent_d       = 1'b1;
				absent_start_d = now;
			end
		end
		absent_ms = absent_d ? (now - absent_start_d) : '0;
	end

	// Mode transitions for this tick.
	always_comb begin
		mode_d        = mode_q;
		alert_start_d = alert_start_q;
		clear_cd      = 1'b0;
		unique case (mode_q)
			pscr_pkg::MODE_ACTIVE: begin
				if (present) begin
					if (accum_upd >= cfg.sit_threshold_ms) begin
						alert_start_d = now;
						mode_d        = pscr_pkg::MODE_ALERT;
					end
				end else if (absent_ms >= cfg.sleep_delay_ms) begin
					clear_cd = 1'b1;
					mode_d   = pscr_pkg::MODE_SLEEP;
				end else if (absent_ms >= cfg.summary_delay_ms) begin
					clear_cd = 1'b1;
					mode_d   = pscr_pkg::MODE_SUMMARY;
				end else if (absent_ms >= cfg.reset_delay_ms) begin
					clear_cd = 1'b1;
				end
			end
			pscr_pkg::MODE_ALERT: begin
				if (present || ((now - alert_start_q) >= cfg.alert_dismiss_ms)) begin
					clear_cd = 1'b1;
					mode_d   = pscr_pkg::MODE_ACTIVE;
				end
			end
			pscr_pkg::MODE_SUMMARY: begin
				if (present) begin
					mode_d = pscr_pkg::MODE_ACTIVE;
				end else if (absent_ms >= cfg.sleep_delay_ms) begin
					mode_d = pscr_pkg::MODE_SLEEP;
				end
			end
			pscr_pkg::MODE_SLEEP: begin
				if (present) begin
					mode_d = pscr_pkg::MODE_ACTIVE;
				end
			end
			default: ;
		endcase
		accum_d = clear_cd ? '0 : accum_upd;
	end

	// Result of the tick, still in milliseconds.
	always_comb begin
		step.mode         = mode_d;
		step.changed      = (mode_d != mode_q);
		step.sit_accum_ms = accum_d;
		step.countdown_ms = (accum_d >= cfg.sit_threshold_ms) ? '0
		                  : (cfg.sit_threshold_ms - accum_d);
	end

	// Controller state, updated once per tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= pscr_pkg::MODE_ACTIVE;
			accum_q        <= '0;
			was_present_q  <= 1'b0;
			last_present_q <= '0;
			absent_q       <= 1'b0;
			absent_start_q <= '0;
			alert_start_q  <= '0;
		end else if (step_en) begin
			mode_q         <= mode_d;
			accum_q        <= accum_d;
			was_present_q  <= clear_cd ? 1'b0 : was_present_d;
			last_present_q <= last_present_d;
			absent_q       <= absent_d;
			absent_start_q <= absent_start_d;
			alert_start_q  <= alert_start_d;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/pscr_div1000.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pscr_div1000 (
	input  wire  [pscr_pkg::TIME_W-1:0] ms,
	output logic [pscr_pkg::SEC_W-1:0]  sec
);

	localparam int PW = pscr_pkg::TIME_W + pscr_pkg::MAGIC_W;

	logic [PW-1:0] prod;

	// Reciprocal multiply; the quotient of a 32-bit value fits in 23 bits.
	always_comb begin
		prod = {{pscr_pkg::MAGIC_W{1'b0}}, ms} * {{pscr_pkg::TIME_W{1'b0}}, pscr_pkg::DIV_MAGIC};
		sec  = prod[pscr_pkg::DIV_SHIFT +: pscr_pkg::SEC_W];
	end

endmodule

`default_nettype wire

// ----- rtl/presence_screen_mode_controller.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Screen mode controller driven by presence ticks. Each accepted tick (presence bit and
// millisecond timestamp) yields exactly one result: the mode after the tick, a flag set when
// the tick changed the mode, and the seconds left before the sitting alert together with the
// accumulated sitting time. A tick passes from acceptance to a valid result through an
// input register, the state update that writes the controller registers, and a result
// register after the millisecond-to-second reciprocal multipliers. One tick is accepted in
// every cycle when the result side keeps up. Thresholds are written through the
// configuration channel, which is always ready; write them only while no tick is in flight.
module presence_screen_mode_controller (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire  [pscr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire  [pscr_pkg::TIME_W-1:0]      cfg_data,
	input  wire                              in_valid,
	output logic                             in_ready,
	input  wire                              person_present,
	input  wire  [pscr_pkg::TIME_W-1:0]      time_ms,
	output logic                             out_valid,
	input  wire                              out_ready,
	output logic [1:0]                       screen_mode,
	output logic                             mode_changed,
	output logic [pscr_pkg::SEC_W-1:0]       countdown_sec,
	output logic [pscr_pkg::SEC_W-1:0]       sitting_sec
);

	pscr_pkg::cfg_t  cfg;
	pscr_pkg::step_t step;

	logic                          valid_s1;
	logic                          present_s1;
	logic [pscr_pkg::TIME_W-1:0]   time_s1;
	logic                          valid_s2;
	pscr_pkg::step_t               step_s2;
	logic [pscr_pkg::SEC_W-1:0]    cd_sec;
	logic [pscr_pkg::SEC_W-1:0]    sit_sec;
	logic                          out_valid_q;
	logic                          adv_out;
	logic                          adv_s2;

	// Pipeline flow: a stage moves on when the next one is empty or moving.
	assign adv_out  = valid_s2 && (!out_valid_q || out_ready);
	assign adv_s2   = valid_s1 && (!valid_s2 || adv_out);
	assign in_ready = !valid_s1 || adv_s2;
	assign out_valid = out_valid_q;

	pscr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pscr_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (adv_s2),
		.present (present_s1),
		.now     (time_s1),
		.cfg     (cfg),
		.step    (step)
	);

	pscr_div1000 u_div_cd (
		.ms  (step_s2.countdown_ms),
		.sec (cd_sec)
	);

	pscr_div1000 u_div_sit (
		.ms  (step_s2.sit_accum_ms),
		.sec (sit_sec)
	);

	// Valid flags of the three stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv_s2) begin
				valid_s2 <= 1'b1;
			end else if (adv_out) begin
				valid_s2 <= 1'b0;
			end
			if (adv_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			present_s1 <= person_present;
			time_s1    <= time_ms;
		end
		if (adv_s2) begin
			step_s2 <= step;
		end
		if (adv_out) begin
			screen_mode   <= step_s2.mode;
			mode_changed  <= step_s2.changed;
			countdown_sec <= cd_sec;
			sitting_sec   <= sit_sec;
		end
	end

endmodule

`default_nettype wire
